@@ hdl/vis_pkg.sv @@
// Shared widths, codes and reset values for the vblank interval statistics unit.
// Depends on nothing; the other files except vis_queue refer to it by scoped names.
package vis_pkg;
  localparam int unsigned STAMP_W   = 63;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned WTICKS_W  = 40;
  localparam int unsigned WIN_IDX_W = 6;
  localparam logic [WTICKS_W-1:0] WTICKS_RESET = 40'd10000000;
  localparam logic KIND_STAT = 1'b0;
  localparam logic KIND_WIN  = 1'b1;
endpackage

@@ hdl/vblank_interval_statistics_unit.sv @@
// Top level of the vblank interval statistics unit.
// Instantiates vis_front, vis_queue and vis_back; uses vis_pkg.
//
// Channel   Direction  Handshake
// sample    in         start && !busy accepts sample_stamp_i, last_sample_i
// config    in         cfg_we_i writes cfg_wdata_i into window_ticks
// result    out        result_valid_o marks one result for one cycle
//
// Samples are accepted one per cycle into the stamp memory while busy is low, until a set closes.
// After the last sample the block stays busy through the scans over the stamp and delta memories
// (no median passes if nd = 0).
// Results leave on strobes and the receiver cannot stall them.
// Reset clears the sample count, the queue and the sequencer; memories are not cleared.
module vblank_interval_statistics_unit #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned MAX_WINDOWS = 63
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [vis_pkg::STAMP_W-1:0]            sample_stamp_i,
  input  logic                                   last_sample_i,
  input  logic                                   cfg_we_i,
  input  logic [vis_pkg::WTICKS_W-1:0]           cfg_wdata_i,
  output logic                                   result_valid_o,
  output logic                                   result_kind_o,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]       stored_count_o,
  output logic [$clog2(MAX_SAMPLES)-1:0]         delta_count_o,
  output logic [vis_pkg::STAMP_W-1:0]            first_stamp_o,
  output logic [vis_pkg::STAMP_W-1:0]            final_stamp_o,
  output logic [vis_pkg::STAMP_W-1:0]            min_delta_o,
  output logic [vis_pkg::STAMP_W-1:0]            max_delta_o,
  output logic [vis_pkg::SUM_W-1:0]              delta_sum_o,
  output logic [vis_pkg::SUM_W-1:0]              median_twice_o,
  output logic [vis_pkg::WIN_IDX_W-1:0]          window_index_o,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]       window_events_o,
  output logic                                   last_of_run_o
);
  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  logic          accept, push, pop, q_empty, back_busy;
  logic [CW-1:0] push_cnt, head_cnt;
  logic [AW-1:0] raddr;
  logic [vis_pkg::STAMP_W-1:0] rdata;

  assign accept = start && !busy;
  assign busy   = !q_empty || back_busy;

  vis_front #(.MAX_SAMPLES(MAX_SAMPLES), .AW(AW), .CW(CW)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .stamp_i(sample_stamp_i), .last_i(last_sample_i),
    .push_o(push), .push_cnt_o(push_cnt), .raddr_i(raddr), .rdata_o(rdata)
  );

  vis_queue #(.W(CW)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_cnt), .pop_i(pop),
    .head_o(head_cnt), .empty_o(q_empty)
  );

  vis_back #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_WINDOWS(MAX_WINDOWS), .AW(AW), .CW(CW)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .req_valid_i(!q_empty), .req_cnt_i(head_cnt),
    .pop_o(pop), .busy_o(back_busy), .raddr_o(raddr), .rdata_i(rdata),
    .result_valid_o, .result_kind_o, .stored_count_o, .delta_count_o, .first_stamp_o,
    .final_stamp_o, .min_delta_o, .max_delta_o, .delta_sum_o, .median_twice_o,
    .window_index_o, .window_events_o, .last_of_run_o
  );

  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_sample_i) |=> busy) else $error("closed set did not raise busy");
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_of_run_o) |-> busy) else $error("result outside a run");
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_busy |-> !accept) else $error("sample accepted during a scan");
endmodule

@@ hdl/vis_front.sv @@
// Front part: takes sample requests, stores kept stamps and closes a set on its last request.
// Holds the stamp memory with a registered read port for the back part. Uses vis_pkg.
module vis_front #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned AW = 12,
  parameter int unsigned CW = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [vis_pkg::STAMP_W-1:0]   stamp_i,
  input  logic                          last_i,
  output logic                          push_o,
  output logic [CW-1:0]                 push_cnt_o,
  input  logic [AW-1:0]                 raddr_i,
  output logic [vis_pkg::STAMP_W-1:0]   rdata_o
);
  logic [vis_pkg::STAMP_W-1:0] mem [MAX_SAMPLES];
  logic [CW-1:0] cnt_q, cnt_d;
  logic          full;

  assign full       = (cnt_q == CW'(MAX_SAMPLES));
  assign push_o     = accept_i && last_i;
  assign push_cnt_o = full ? cnt_q : cnt_q + CW'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (accept_i) begin
      if (!full) cnt_d = cnt_q + CW'(1);
      if (last_i) cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !full) mem[cnt_q[AW-1:0]] <= stamp_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ hdl/vis_queue.sv @@
// Two-entry queue of closed-set requests between the front and back parts.
// Carries the kept sample count of each set. Uses no package items.
module vis_queue #(
  parameter int unsigned W = 13
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic [W-1:0] head_o,
  output logic         empty_o
);
  logic [W-1:0] slot_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   fill_q;

  assign empty_o = (fill_q == 2'd0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_data_i;
  end
endmodule

@@ hdl/vis_back.sv @@
// Back part: sequencer that scans a closed set, finds the median by bitwise selection,
// counts windows and issues the results. Holds the delta memory. Uses vis_pkg.
module vis_back #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned MAX_WINDOWS = 63,
  parameter int unsigned AW = 12,
  parameter int unsigned CW = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vis_pkg::WTICKS_W-1:0]    cfg_wdata_i,
  input  logic                            req_valid_i,
  input  logic [CW-1:0]                   req_cnt_i,
  output logic                            pop_o,
  output logic                            busy_o,
  output logic [AW-1:0]                   raddr_o,
  input  logic [vis_pkg::STAMP_W-1:0]     rdata_i,
  output logic                            result_valid_o,
  output logic                            result_kind_o,
  output logic [CW-1:0]                   stored_count_o,
  output logic [AW-1:0]                   delta_count_o,
  output logic [vis_pkg::STAMP_W-1:0]     first_stamp_o,
  output logic [vis_pkg::STAMP_W-1:0]     final_stamp_o,
  output logic [vis_pkg::STAMP_W-1:0]     min_delta_o,
  output logic [vis_pkg::STAMP_W-1:0]     max_delta_o,
  output logic [vis_pkg::SUM_W-1:0]       delta_sum_o,
  output logic [vis_pkg::SUM_W-1:0]       median_twice_o,
  output logic [vis_pkg::WIN_IDX_W-1:0]   window_index_o,
  output logic [CW-1:0]                   window_events_o,
  output logic                            last_of_run_o
);
  localparam int unsigned SW = vis_pkg::STAMP_W;
  localparam int unsigned XW = vis_pkg::SUM_W;
  localparam int unsigned KW = vis_pkg::WIN_IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DELTA, S_MED, S_PREP, S_DIV, S_STAT, S_WIN
  } state_e;

  state_e        state_q;
  logic [SW-1:0] dmem [MAX_SAMPLES];
  logic [SW-1:0] drd_q;
  logic [vis_pkg::WTICKS_W-1:0] wticks_q;
  logic [CW-1:0] n_q, issue_q, pidx_q, ca_q, cb_q, wcnt_q;
  logic [AW-1:0] nd_q;
  logic          pend_q;
  logic [SW-1:0] first_q, final_q, prev_q, mn_q, mx_q, ans_a_q, ans_b_q, diff_q;
  logic [XW-1:0] sum_q, med_q, lo_q;
  logic [5:0]    bit_q;
  logic [KW-1:0] nwin_q, k_q;

  logic [CW-1:0] len, ca_nx, cb_nx, wcnt_nx, ka, kb;
  logic          pass_end, inc, dwe, hit_a, hit_b, hit_w;
  logic [SW-1:0] dv, ans_a_nx, ans_b_nx, bitmask;
  logic [XW:0]   sum_add;
  logic [XW-1:0] ta, tb, off, hi;
  logic [AW-1:0] nd_nx;

  assign len      = (state_q == S_MED) ? CW'(nd_q) : n_q;
  assign pass_end = pend_q && (pidx_q == len - CW'(1));
  assign raddr_o  = issue_q[AW-1:0];
  assign pop_o    = (state_q == S_IDLE) && req_valid_i;
  assign busy_o   = (state_q != S_IDLE);

  assign inc     = rdata_i > prev_q;
  assign dv      = rdata_i - prev_q;
  assign dwe     = (state_q == S_DELTA) && pend_q && (pidx_q != '0) && inc;
  assign nd_nx   = nd_q + AW'(dwe);
  assign sum_add = {1'b0, sum_q} + (XW+1)'(dv);

  assign bitmask  = SW'(1) << bit_q;
  assign ta       = {1'b0, ans_a_q | bitmask};
  assign tb       = {1'b0, ans_b_q | bitmask};
  assign hit_a    = {1'b0, drd_q} < ta;
  assign hit_b    = {1'b0, drd_q} < tb;
  assign ca_nx    = ca_q + CW'(pend_q && hit_a);
  assign cb_nx    = cb_q + CW'(pend_q && hit_b);
  assign kb       = CW'(nd_q >> 1);
  assign ka       = nd_q[0] ? kb : kb - CW'(1);
  assign ans_a_nx = (ca_nx <= ka) ? (ans_a_q | bitmask) : ans_a_q;
  assign ans_b_nx = (cb_nx <= kb) ? (ans_b_q | bitmask) : ans_b_q;

  assign off     = {1'b0, rdata_i} - {1'b0, first_q};
  assign hi      = lo_q + XW'(wticks_q);
  assign hit_w   = (off >= lo_q) && (off < hi);
  assign wcnt_nx = wcnt_q + CW'(pend_q && hit_w);

  always_ff @(posedge clk_i) begin
    if (dwe) dmem[nd_q] <= dv;
    drd_q <= dmem[issue_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      wticks_q       <= vis_pkg::WTICKS_RESET;
      result_valid_o <= 1'b0;
      issue_q        <= '0;
      pend_q         <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) wticks_q <= cfg_wdata_i;
      if (state_q == S_DELTA || state_q == S_MED || state_q == S_WIN) begin
        if (issue_q < len) begin
          issue_q <= issue_q + CW'(1);
          pend_q  <= 1'b1;
          pidx_q  <= issue_q;
        end else begin
          pend_q <= 1'b0;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            n_q     <= req_cnt_i;
            nd_q    <= '0;
            mn_q    <= '0;
            mx_q    <= '0;
            sum_q   <= '0;
            med_q   <= '0;
            first_q <= '0;
            final_q <= '0;
            issue_q <= '0;
            pend_q  <= 1'b0;
            state_q <= (req_cnt_i == '0) ? S_PREP : S_DELTA;
          end
        end
        S_DELTA: begin
          if (pend_q) begin
            prev_q <= rdata_i;
            if (pidx_q == '0) first_q <= rdata_i;
            if (dwe) begin
              nd_q  <= nd_nx;
              if (nd_q == '0 || dv < mn_q) mn_q <= dv;
              if (dv > mx_q) mx_q <= dv;
              sum_q <= sum_add[XW] ? '1 : sum_add[XW-1:0];
            end
            if (pass_end) begin
              final_q <= rdata_i;
              issue_q <= '0;
              pend_q  <= 1'b0;
              bit_q   <= 6'(SW - 1);
              ans_a_q <= '0;
              ans_b_q <= '0;
              ca_q    <= '0;
              cb_q    <= '0;
              state_q <= (nd_nx != '0) ? S_MED : S_PREP;
            end
          end
        end
        S_MED: begin
          ca_q <= ca_nx;
          cb_q <= cb_nx;
          if (pass_end) begin
            issue_q <= '0;
            pend_q  <= 1'b0;
            ca_q    <= '0;
            cb_q    <= '0;
            ans_a_q <= ans_a_nx;
            ans_b_q <= ans_b_nx;
            if (bit_q == 6'd0) begin
              med_q   <= {1'b0, ans_a_nx} + {1'b0, ans_b_nx};
              state_q <= S_PREP;
            end else begin
              bit_q <= bit_q - 6'd1;
            end
          end
        end
        S_PREP: begin
          diff_q <= final_q - first_q;
          nwin_q <= '0;
          if (n_q != '0 && final_q >= first_q && wticks_q != '0) state_q <= S_DIV;
          else state_q <= S_STAT;
        end
        S_DIV: begin
          if (diff_q >= SW'(wticks_q) && nwin_q < KW'(MAX_WINDOWS)) begin
            diff_q <= diff_q - SW'(wticks_q);
            nwin_q <= nwin_q + KW'(1);
          end else begin
            state_q <= S_STAT;
          end
        end
        S_STAT: begin
          result_valid_o  <= 1'b1;
          result_kind_o   <= vis_pkg::KIND_STAT;
          stored_count_o  <= n_q;
          delta_count_o   <= nd_q;
          first_stamp_o   <= first_q;
          final_stamp_o   <= final_q;
          min_delta_o     <= mn_q;
          max_delta_o     <= mx_q;
          delta_sum_o     <= sum_q;
          median_twice_o  <= med_q;
          window_index_o  <= '0;
          window_events_o <= '0;
          last_of_run_o   <= (nwin_q == '0);
          k_q     <= '0;
          lo_q    <= '0;
          wcnt_q  <= '0;
          issue_q <= '0;
          pend_q  <= 1'b0;
          state_q <= (nwin_q == '0) ? S_IDLE : S_WIN;
        end
        S_WIN: begin
          wcnt_q <= wcnt_nx;
          if (pass_end) begin
            result_valid_o  <= 1'b1;
            result_kind_o   <= vis_pkg::KIND_WIN;
            stored_count_o  <= '0;
            delta_count_o   <= '0;
            first_stamp_o   <= '0;
            final_stamp_o   <= '0;
            min_delta_o     <= '0;
            max_delta_o     <= '0;
            delta_sum_o     <= '0;
            median_twice_o  <= '0;
            window_index_o  <= k_q;
            window_events_o <= wcnt_nx;
            last_of_run_o   <= (k_q + KW'(1) == nwin_q);
            wcnt_q  <= '0;
            issue_q <= '0;
            pend_q  <= 1'b0;
            k_q     <= k_q + KW'(1);
            lo_q    <= hi;
            if (k_q + KW'(1) == nwin_q) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q != S_IDLE)) else $error("set request popped without starting a scan");
  a_win_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WIN) |-> (k_q < nwin_q)) else $error("window index beyond window count");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_kind_o == vis_pkg::KIND_STAT) |-> (window_events_o == '0))
    else $error("statistics result carries a window count");
endmodule

@@ verif/vblank_interval_statistics_unit_test.sv @@
// Self-checking testbench for the vblank interval statistics unit.
// Drives sample sets, predicts statistics and window results; needs vis_pkg and the RTL.
module vblank_interval_statistics_unit_test;

  localparam int unsigned DEPTH = 4096;
  localparam int unsigned WIN_CAP = 63;
  localparam logic [62:0] STAMP_MAX = {63{1'b1}};
  localparam logic [39:0] WTICKS_MAX = {40{1'b1}};

  typedef struct {
    logic        kind;
    logic [12:0] stored;
    logic [11:0] deltas;
    logic [62:0] first_s;
    logic [62:0] fin_s;
    logic [62:0] mn;
    logic [62:0] mx;
    logic [63:0] sum;
    logic [63:0] med;
    logic [5:0]  widx;
    logic [12:0] wev;
    logic        lastr;
  } vis_result_t;

  typedef struct {
    logic [62:0] stamp;
    logic        last;
    bit          typed;
    vis_result_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [62:0] sample_stamp_i = '0;
  logic        last_sample_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [39:0] cfg_wdata_i = '0;
  logic        result_valid_o;
  logic        result_kind_o;
  logic [12:0] stored_count_o;
  logic [11:0] delta_count_o;
  logic [62:0] first_stamp_o;
  logic [62:0] final_stamp_o;
  logic [62:0] min_delta_o;
  logic [62:0] max_delta_o;
  logic [63:0] delta_sum_o;
  logic [63:0] median_twice_o;
  logic [5:0]  window_index_o;
  logic [12:0] window_events_o;
  logic        last_of_run_o;

  logic [62:0] kept_stamps[$];
  logic [39:0] window_len = vis_pkg::WTICKS_RESET;
  vis_result_t pending_results[$];
  int          error_count = 0;
  stim_row_t   directed_rows[$];

  vblank_interval_statistics_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .sample_stamp_i(sample_stamp_i), .last_sample_i(last_sample_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .result_valid_o(result_valid_o), .result_kind_o(result_kind_o),
    .stored_count_o(stored_count_o), .delta_count_o(delta_count_o),
    .first_stamp_o(first_stamp_o), .final_stamp_o(final_stamp_o),
    .min_delta_o(min_delta_o), .max_delta_o(max_delta_o),
    .delta_sum_o(delta_sum_o), .median_twice_o(median_twice_o),
    .window_index_o(window_index_o), .window_events_o(window_events_o),
    .last_of_run_o(last_of_run_o)
  );

  always #2 clk_i = ~clk_i;

  // Closes the current set and queues the statistics result and window results.
  task automatic close_interval_set();
    logic [63:0] deltas[$];
    logic [63:0] dd, sum, med, span, lo, hi, off;
    logic [62:0] first_v, fin_v, mn, mx;
    int n, nwin, cnt;
    vis_result_t r;
    n = kept_stamps.size();
    first_v = '0;
    fin_v = '0;
    mn = '0;
    mx = '0;
    sum = '0;
    med = '0;
    nwin = 0;
    if (n > 0) begin
      first_v = kept_stamps[0];
      fin_v = kept_stamps[n-1];
    end
    for (int i = 1; i < n; i++) begin
      if (kept_stamps[i] > kept_stamps[i-1]) begin
        dd = {1'b0, kept_stamps[i]} - {1'b0, kept_stamps[i-1]};
        deltas.insert(deltas.size(), dd);
        if (deltas.size() == 1 || dd[62:0] < mn) mn = dd[62:0];
        if (dd[62:0] > mx) mx = dd[62:0];
        sum = (sum > ~64'd0 - dd) ? ~64'd0 : sum + dd;
      end
    end
    if (deltas.size() > 0) begin
      deltas.sort();
      if (deltas.size() % 2) med = 2 * deltas[deltas.size()/2];
      else med = deltas[deltas.size()/2 - 1] + deltas[deltas.size()/2];
    end
    if (n > 0 && fin_v >= first_v && window_len != 0) begin
      span = ({1'b0, fin_v} - {1'b0, first_v}) / window_len;
      nwin = (span > WIN_CAP) ? WIN_CAP : int'(span);
    end
    r = '{vis_pkg::KIND_STAT, n[12:0], 12'(deltas.size()), first_v, fin_v, mn, mx, sum, med,
          6'd0, 13'd0, nwin == 0};
    pending_results.insert(pending_results.size(), r);
    for (int k = 0; k < nwin; k++) begin
      lo = k * {24'd0, window_len};
      hi = lo + window_len;
      cnt = 0;
      for (int i = 0; i < n; i++) begin
        off = {1'b0, kept_stamps[i]} - {1'b0, first_v};
        if (off >= lo && off < hi) cnt++;
      end
      r = '{vis_pkg::KIND_WIN, 13'd0, 12'd0, 63'd0, 63'd0, 63'd0, 63'd0, 64'd0, 64'd0,
            k[5:0], cnt[12:0], k + 1 == nwin};
      pending_results.insert(pending_results.size(), r);
    end
    kept_stamps.delete();
  endtask

  task automatic send_request(logic [62:0] stamp, logic last);
    sample_stamp_i <= stamp;
    last_sample_i <= last;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (kept_stamps.size() < DEPTH) kept_stamps.insert(kept_stamps.size(), stamp);
    if (last) close_interval_set();
  endtask

  task automatic idle_gap();
    int len;
    case ($urandom_range(0, 9))
      0, 1, 2: len = $urandom_range(1, 3);
      3: len = $urandom_range(10, 60);
      default: len = 0;
    endcase
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  task automatic write_window(logic [39:0] w);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() > 0 || busy) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_len = w;
  endtask

  function automatic logic [62:0] random_stamp();
    return 63'({$urandom, $urandom});
  endfunction

  task automatic random_set(output int sent);
    int len;
    logic [62:0] s;
    logic [63:0] scale;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 24);
    scale = (window_len == 0) ? 64'd1000 : {24'd0, window_len};
    case ($urandom_range(0, 3))
      0: s = 63'($urandom_range(0, 1000));
      1: s = STAMP_MAX - 63'($urandom_range(0, 1000));
      default: s = random_stamp();
    endcase
    if (s > STAMP_MAX / 2 && $urandom_range(0, 1)) s = s / 2;
    for (int i = 0; i < len; i++) begin
      send_request(s, i == len - 1);
      idle_gap();
      case ($urandom_range(0, 9))
        0: s = s;
        1: s = s - 63'($urandom_range(0, 5000));
        2: s = random_stamp();
        default: s = s + 63'(({$urandom, $urandom} % (2 * scale + 1)) / (len / 8 + 1));
      endcase
    end
    sent = len;
  endtask

  function automatic void check_field(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, e, a);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    vis_result_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d", $time,
                 result_kind_o);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("result_kind", e.kind, result_kind_o);
        check_field("stored_count", e.stored, stored_count_o);
        check_field("delta_count", e.deltas, delta_count_o);
        check_field("first_stamp", e.first_s, first_stamp_o);
        check_field("final_stamp", e.fin_s, final_stamp_o);
        check_field("min_delta", e.mn, min_delta_o);
        check_field("max_delta", e.mx, max_delta_o);
        check_field("delta_sum", e.sum, delta_sum_o);
        check_field("median_twice", e.med, median_twice_o);
        check_field("window_index", e.widx, window_index_o);
        check_field("window_events", e.wev, window_events_o);
        check_field("last_of_run", e.lastr, last_of_run_o);
      end
    end
  end

  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    stim_row_t row;
    logic [39:0] phase_w[$];
    vis_result_t typed;
    int sent;

    // A set of one sample has no deltas and no windows.
    row = '{63'd0, 1'b1, 1'b1, '{vis_pkg::KIND_STAT, 13'd1, 12'd0, 63'd0, 63'd0, 63'd0,
            63'd0, 64'd0, 64'd0, 6'd0, 13'd0, 1'b1}};
    directed_rows.insert(directed_rows.size(), row);
    row = '{STAMP_MAX, 1'b1, 1'b1, '{vis_pkg::KIND_STAT, 13'd1, 12'd0, STAMP_MAX, STAMP_MAX,
            63'd0, 63'd0, 64'd0, 64'd0, 6'd0, 13'd0, 1'b1}};
    directed_rows.insert(directed_rows.size(), row);
    // The delta sum saturates.
    for (int i = 0; i < 6; i++) begin
      row = '{(i % 2) ? STAMP_MAX : 63'd0, i == 5, 1'b0, typed};
      directed_rows.insert(directed_rows.size(), row);
    end
    // Decreasing overall, then stamps below the first one with two windows.
    directed_rows.insert(directed_rows.size(), '{63'd500, 1'b0, 1'b0, typed});
    directed_rows.insert(directed_rows.size(), '{63'd100, 1'b0, 1'b0, typed});
    directed_rows.insert(directed_rows.size(), '{63'd300, 1'b1, 1'b0, typed});
    directed_rows.insert(directed_rows.size(), '{63'd100, 1'b0, 1'b0, typed});
    directed_rows.insert(directed_rows.size(), '{63'd50, 1'b0, 1'b0, typed});
    directed_rows.insert(directed_rows.size(), '{63'd10000100, 1'b0, 1'b0, typed});
    directed_rows.insert(directed_rows.size(), '{63'd25000100, 1'b1, 1'b0, typed});
    // Odd number of deltas, then equal stamps.
    directed_rows.insert(directed_rows.size(), '{63'd0, 1'b0, 1'b0, typed});
    directed_rows.insert(directed_rows.size(), '{63'd10, 1'b0, 1'b0, typed});
    directed_rows.insert(directed_rows.size(), '{63'd30, 1'b0, 1'b0, typed});
    directed_rows.insert(directed_rows.size(), '{63'd60, 1'b1, 1'b0, typed});
    directed_rows.insert(directed_rows.size(), '{63'd7, 1'b0, 1'b0, typed});
    directed_rows.insert(directed_rows.size(), '{63'd7, 1'b1, 1'b0, typed});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].stamp, directed_rows[i].last);
      if (directed_rows[i].typed) begin
        void'(pending_results.pop_back());
        pending_results.insert(pending_results.size(), directed_rows[i].want);
      end
      idle_gap();
    end

    phase_w = '{40'd1, 40'd0, vis_pkg::WTICKS_RESET, WTICKS_MAX, 40'd0, 40'd0};
    phase_w[4] = 40'($urandom_range(2, 5000));
    phase_w[5] = 40'({$urandom, $urandom});
    foreach (phase_w[p]) begin
      write_window(phase_w[p]);
      for (int items = 0; items < 80; items += sent) begin
        random_set(sent);
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() > 0 || busy) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
